>>> rtl/core/sirt_pkg.sv
// Shared types and constants for the sorted interval reservation table.
// Holds the table entry layout, op and status codes, and inter-module structs.
// No dependencies.
package sirt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W    = 2;
	localparam int TIME_W  = 13;
	localparam int ROOM_W  = 16;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 5;

	// 24 hours in hours * 256
	localparam logic [TIME_W-1:0] DAY_LIMIT = 13'd6144;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_GAP    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] beg;
		logic [TIME_W-1:0] fin;
		logic [ROOM_W-1:0] room;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic eq;
		logic fits_before;
		logic clears_after;
	} cmp_t;

	typedef struct packed {
		logic               valid;
		logic [STAT_W-1:0]  status;
		logic [TIME_W-1:0]  f_end;
		logic [ROOM_W-1:0]  f_room;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

>>> rtl/core/sirt_store.sv
// Entry store: one write port and one registered read port.
// Depends on sirt_pkg.
module sirt_store
	import sirt_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem_q[req.rd_addr];
	end

endmodule

>>> rtl/core/sirt_cmp.sv
// Shared compare unit: tests one stored entry against the request key.
// Depends on sirt_pkg.
module sirt_cmp
	import sirt_pkg::*;
(
	input  entry_t            entry,
	input  logic [TIME_W-1:0] key_b,
	input  logic [TIME_W-1:0] key_e,
	output cmp_t              cmp
);

	always_comb begin
		cmp.eq           = (entry.beg == key_b);
		cmp.fits_before  = (key_e <= entry.beg);
		cmp.clears_after = (entry.fin <= key_b);
	end

endmodule

>>> rtl/core/sirt_seq.sv
// Sequencer: scans the store through the compare unit, then shifts entries for an insert or remove.
// Depends on sirt_pkg; drives sirt_store and reads sirt_cmp.
module sirt_seq
	import sirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   op,
	input  logic [TIME_W-1:0] begin_time,
	input  logic [TIME_W-1:0] end_time,
	input  logic [ROOM_W-1:0] room_number,
	output logic              busy,
	output mem_req_t          req,
	input  entry_t            rd_data,
	output logic [TIME_W-1:0] key_b,
	output logic [TIME_W-1:0] key_e,
	input  cmp_t              cmp,
	output res_t              res
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_PUT   = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [TIME_W-1:0] b_q, b_d, e_q, e_d;
	logic [ROOM_W-1:0] r_q, r_d;
	logic [CNT_W-1:0]  n_q, n_d;
	logic [CNT_W-1:0]  rp_q, rp_d;
	logic [CNT_W-1:0]  src_q, src_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic              vld_q, vld_d;
	logic              after_q, after_d;

	logic              last;
	logic              ins_gap;
	logic              ins_back;
	logic [CNT_W-1:0]  place_pos;
	logic [CNT_W-1:0]  n_dec;
	logic [CNT_W-1:0]  n_inc;
	logic [CNT_W-1:0]  wr_up;
	logic [CNT_W-1:0]  wr_dn;
	logic              bad_ival;

	assign busy  = (state_q != S_IDLE);
	assign key_b = b_q;
	assign key_e = e_q;

	always_comb begin
		n_dec     = n_q - CNT_W'(1);
		n_inc     = n_q + CNT_W'(1);
		wr_up     = src_q + CNT_W'(1);
		wr_dn     = src_q - CNT_W'(1);
		last      = (src_q == n_dec);
		ins_gap   = ((src_q == '0) || after_q) && cmp.fits_before;
		ins_back  = last && cmp.clears_after;
		place_pos = ins_gap ? src_q : n_q;
		bad_ival  = (begin_time >= end_time) || (begin_time > DAY_LIMIT) ||
			(end_time > DAY_LIMIT);

		state_d = state_q;
		op_d    = op_q;
		b_d     = b_q;
		e_d     = e_q;
		r_d     = r_q;
		n_d     = n_q;
		rp_d    = rp_q;
		src_d   = src_q;
		pos_d   = pos_q;
		vld_d   = vld_q;
		after_d = after_q;

		req         = '0;
		req.rd_addr = rp_q[IDX_W-1:0];
		res         = '0;
		res.count   = COUNT_W'(n_q);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d  = op;
					b_d   = begin_time;
					e_d   = end_time;
					r_d   = room_number;
					rp_d  = '0;
					vld_d = 1'b0;
					if (op == OP_INSERT) begin
						if (bad_ival) begin
							res.valid  = 1'b1;
							res.status = ST_INVALID;
						end else if (n_q == '0) begin
							pos_d   = '0;
							state_d = S_PUT;
						end else begin
							state_d = S_SCAN;
						end
					end else if ((op == OP_REMOVE) || (op == OP_FIND)) begin
						if (n_q == '0) begin
							res.valid  = 1'b1;
							res.status = ST_NOT_FOUND;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						res.valid  = 1'b1;
						res.status = ST_INVALID;
					end
				end
			end
			S_SCAN: begin
				rp_d  = rp_q + CNT_W'(1);
				src_d = rp_q;
				vld_d = 1'b1;
				if (vld_q) begin
					if (op_q == OP_INSERT) begin
						after_d = cmp.clears_after;
						if (ins_gap || ins_back) begin
							if (n_q >= CNT_W'(CAPACITY)) begin
								res.valid  = 1'b1;
								res.status = ST_FULL;
								state_d    = S_IDLE;
							end else begin
								pos_d = place_pos;
								if (place_pos == n_q) begin
									state_d = S_PUT;
								end else begin
									// open a hole: copy upwards from the top entry
									state_d = S_SHIFT;
									rp_d    = n_dec;
									vld_d   = 1'b0;
								end
							end
						end else if (last) begin
							res.valid  = 1'b1;
							res.status = ST_NO_GAP;
							state_d    = S_IDLE;
						end
					end else begin
						if (cmp.eq) begin
							if (op_q == OP_FIND) begin
								res.valid  = 1'b1;
								res.status = ST_OK;
								res.f_end  = rd_data.fin;
								res.f_room = rd_data.room;
								state_d    = S_IDLE;
							end else if (last) begin
								n_d        = n_dec;
								res.valid  = 1'b1;
								res.status = ST_OK;
								res.count  = COUNT_W'(n_dec);
								state_d    = S_IDLE;
							end else begin
								// close the gap: copy downwards from the next entry
								state_d = S_SHIFT;
								rp_d    = wr_up;
								vld_d   = 1'b0;
							end
						end else if (last) begin
							res.valid  = 1'b1;
							res.status = ST_NOT_FOUND;
							state_d    = S_IDLE;
						end
					end
				end
			end
			S_SHIFT: begin
				src_d = rp_q;
				vld_d = 1'b1;
				if (op_q == OP_INSERT) begin
					rp_d = rp_q - CNT_W'(1);
				end else begin
					rp_d = rp_q + CNT_W'(1);
				end
				if (vld_q) begin
					req.we      = 1'b1;
					req.wr_data = rd_data;
					if (op_q == OP_INSERT) begin
						req.wr_addr = wr_up[IDX_W-1:0];
						if (src_q == pos_q) begin
							state_d = S_PUT;
						end
					end else begin
						req.wr_addr = wr_dn[IDX_W-1:0];
						if (last) begin
							n_d        = n_dec;
							res.valid  = 1'b1;
							res.status = ST_OK;
							res.count  = COUNT_W'(n_dec);
							state_d    = S_IDLE;
						end
					end
				end
			end
			S_PUT: begin
				req.we           = 1'b1;
				req.wr_addr      = pos_q[IDX_W-1:0];
				req.wr_data.beg  = b_q;
				req.wr_data.fin  = e_q;
				req.wr_data.room = r_q;
				n_d              = n_inc;
				res.valid        = 1'b1;
				res.status       = ST_OK;
				res.count        = COUNT_W'(n_inc);
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			vld_q   <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		b_q     <= b_d;
		e_q     <= e_d;
		r_q     <= r_d;
		rp_q    <= rp_d;
		src_q   <= src_d;
		pos_q   <= pos_d;
		after_q <= after_d;
	end

endmodule

>>> rtl/core/sorted_interval_reservation_table.sv
// Sorted interval reservation table, top level.
// Depends on sirt_pkg, sirt_store, sirt_cmp and sirt_seq.
//
// Usage:
//   Command channel: a word (op, begin_time, end_time, room_number) is taken
//   at a rising edge with start high and busy low. op 0 inserts an interval,
//   1 removes the first entry with a matching begin, 2 finds it.
//   Result channel: done is high for exactly one cycle with status,
//   found_end, found_room and entry_count valid; the receiver cannot stall,
//   so the word must be taken in that cycle.
//   Flow: a rejected command is answered without leaving idle, and an insert
//   into an empty table goes straight to the write of the new entry. Otherwise
//   the store is scanned one entry a cycle through its registered read port,
//   stopping at the first match or the first place that fits; a remove then
//   moves the entries above the match down, an insert moves the entries from
//   the top down to its place up and writes the new entry. done is registered
//   from the sequencer's result and, for a command that raised busy, rises as
//   busy falls.
//   Reset clears the entry count, the state and done; stored entries are
//   never used beyond the count, so the store needs no clearing pass.
module sorted_interval_reservation_table
	import sirt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [TIME_W-1:0]  begin_time,
	input  logic [TIME_W-1:0]  end_time,
	input  logic [ROOM_W-1:0]  room_number,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [TIME_W-1:0]  found_end,
	output logic [ROOM_W-1:0]  found_room,
	output logic [COUNT_W-1:0] entry_count
);

	mem_req_t          req;
	entry_t            rd_data;
	cmp_t              cmp;
	res_t              res;
	logic [TIME_W-1:0] key_b;
	logic [TIME_W-1:0] key_e;

	logic               done_q;
	logic [STAT_W-1:0]  status_q;
	logic [TIME_W-1:0]  found_end_q;
	logic [ROOM_W-1:0]  found_room_q;
	logic [COUNT_W-1:0] entry_count_q;

	sirt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.begin_time  (begin_time),
		.end_time    (end_time),
		.room_number (room_number),
		.busy        (busy),
		.req         (req),
		.rd_data     (rd_data),
		.key_b       (key_b),
		.key_e       (key_e),
		.cmp         (cmp),
		.res         (res)
	);

	sirt_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	sirt_cmp u_cmp (
		.entry (rd_data),
		.key_b (key_b),
		.key_e (key_e),
		.cmp   (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// hold the result word until the next one
	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q      <= res.status;
			found_end_q   <= res.f_end;
			found_room_q  <= res.f_room;
			entry_count_q <= res.count;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_end   = found_end_q;
	assign found_room  = found_room_q;
	assign entry_count = entry_count_q;

endmodule

>>> rtl/core/sirt_chk.sv
// Port-level checker for the sorted interval reservation table.
// Depends on sirt_pkg; bound to sorted_interval_reservation_table below.
module sirt_chk
	import sirt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [OP_W-1:0]    op,
	input logic [TIME_W-1:0]  begin_time,
	input logic [TIME_W-1:0]  end_time,
	input logic [ROOM_W-1:0]  room_number,
	input logic               done,
	input logic [STAT_W-1:0]  status,
	input logic [TIME_W-1:0]  found_end,
	input logic [ROOM_W-1:0]  found_room,
	input logic [COUNT_W-1:0] entry_count
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while still busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command finished without a result word");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= COUNT_W'(CAPACITY)))
		else $error("entry count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((found_end == '0) && (found_room == '0)))
		else $error("found fields set on a failed command");

endmodule

bind sorted_interval_reservation_table sirt_chk u_chk (.*);
